// File: src/flos_pkg.sv
// Shared constants, command codes and result type of the first/last occurrence search.
package flos_pkg;

  localparam int unsigned DefaultDepth = 1024;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned OutIdxW      = 10;
  localparam int unsigned ModeW        = 2;

  typedef enum logic [ModeW-1:0] {
    ModeClear  = 2'd0,
    ModeAppend = 2'd1,
    ModeQuery  = 2'd2
  } mode_e;

  typedef struct packed {
    logic               found;
    logic [OutIdxW-1:0] first_index;
    logic [OutIdxW-1:0] last_index;
  } result_t;

endpackage

// File: src/flos_search.sv
// Two-pass binary search sequencer that probes the table through one synchronous read port.
module flos_search #(
  parameter int unsigned TableDepth = flos_pkg::DefaultDepth,
  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1,
  localparam int unsigned CntW = $clog2(TableDepth + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                go_i,
  input  logic [CntW-1:0]                     count_i,
  input  logic signed [flos_pkg::ValueW-1:0]  target_i,
  input  logic signed [flos_pkg::ValueW-1:0]  rdata_i,
  output logic                                rd_en_o,
  output logic [IdxW-1:0]                     rd_addr_o,
  output logic                                busy_o,
  output logic                                done_o,
  output flos_pkg::result_t                   result_o
);
  import flos_pkg::*;

  typedef enum logic {
    StIdle,
    StProbe
  } state_e;

  state_e                    state_q, state_d;
  logic                      last_pass_q, last_pass_d;
  logic [CntW-1:0]           lo_q, lo_d;
  logic [CntW-1:0]           hi_q, hi_d;
  logic [IdxW-1:0]           mid_q, mid_d;
  logic signed [ValueW-1:0]  target_q, target_d;
  logic                      hit_first_q, hit_first_d;
  logic                      hit_last_q, hit_last_d;
  logic [IdxW-1:0]           pos_first_q, pos_first_d;
  logic [IdxW-1:0]           pos_last_q, pos_last_d;
  logic                      done_q, done_d;

  logic                      probe_eq;
  logic                      probe_gt;
  logic [CntW-1:0]           mid_ext;
  logic [CntW-1:0]           lo_n;
  logic [CntW-1:0]           hi_n;

  // Midpoint of the half-open range [lo, hi): lo + (hi - lo - 1) / 2.
  function automatic logic [IdxW-1:0] mid_of(input logic [CntW-1:0] lo,
                                             input logic [CntW-1:0] hi);
    logic [CntW-1:0] span;
    logic [CntW-1:0] sum;
    span = hi - lo - CntW'(1);
    sum  = lo + (span >> 1);
    return sum[IdxW-1:0];
  endfunction

  assign probe_eq = (rdata_i == target_q);
  assign probe_gt = (target_q > rdata_i);
  assign mid_ext  = CntW'(mid_q);

  always_comb begin
    state_d     = state_q;
    last_pass_d = last_pass_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    target_d    = target_q;
    hit_first_d = hit_first_q;
    hit_last_d  = hit_last_q;
    pos_first_d = pos_first_q;
    pos_last_d  = pos_last_q;
    done_d      = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = mid_q;
    lo_n        = lo_q;
    hi_n        = hi_q;

    unique case (state_q)
      StIdle: begin
        if (go_i) begin
          target_d    = target_i;
          last_pass_d = 1'b0;
          hit_first_d = 1'b0;
          hit_last_d  = 1'b0;
          pos_first_d = '0;
          pos_last_d  = '0;
          lo_d        = '0;
          hi_d        = count_i;
          if (count_i != '0) begin
            mid_d     = mid_of('0, count_i);
            rd_en_o   = 1'b1;
            rd_addr_o = mid_d;
            state_d   = StProbe;
          end else begin
            done_d = 1'b1;
          end
        end
      end
      StProbe: begin
        // Narrow the range on the data just read back for mid_q.
        if (probe_eq) begin
          if (last_pass_q) begin
            hit_last_d = 1'b1;
            pos_last_d = mid_q;
            lo_n       = mid_ext + CntW'(1);
          end else begin
            hit_first_d = 1'b1;
            pos_first_d = mid_q;
            hi_n        = mid_ext;
          end
        end else if (probe_gt) begin
          lo_n = mid_ext + CntW'(1);
        end else begin
          hi_n = mid_ext;
        end

        if (lo_n < hi_n) begin
          lo_d      = lo_n;
          hi_d      = hi_n;
          mid_d     = mid_of(lo_n, hi_n);
          rd_en_o   = 1'b1;
          rd_addr_o = mid_d;
        end else if (!last_pass_q) begin
          // Restart over all filled entries for the last occurrence.
          last_pass_d = 1'b1;
          lo_d        = '0;
          hi_d        = count_i;
          mid_d       = mid_of('0, count_i);
          rd_en_o     = 1'b1;
          rd_addr_o   = mid_d;
        end else begin
          done_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      last_pass_q <= 1'b0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      target_q    <= '0;
      hit_first_q <= 1'b0;
      hit_last_q  <= 1'b0;
      pos_first_q <= '0;
      pos_last_q  <= '0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_pass_q <= last_pass_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      mid_q       <= mid_d;
      target_q    <= target_d;
      hit_first_q <= hit_first_d;
      hit_last_q  <= hit_last_d;
      pos_first_q <= pos_first_d;
      pos_last_q  <= pos_last_d;
      done_q      <= done_d;
    end
  end

  assign busy_o               = (state_q != StIdle);
  assign done_o               = done_q;
  assign result_o.found       = hit_first_q | hit_last_q;
  assign result_o.first_index = OutIdxW'(pos_first_q);
  assign result_o.last_index  = OutIdxW'(pos_last_q);

endmodule

// File: src/first_last_occurrence_search.sv
// Top level of the first/last occurrence search: command port, table memory and element count.
//
// The block keeps a table of up to TableDepth signed 32-bit values in one
// single-port-write, single-port-read synchronous memory, plus an element
// count. A command is taken on a rising edge where start_i is high and
// busy_o is low; mode_i selects clear (count to zero, contents kept),
// append (write value_i at the end; ignored once the table is full) or
// query (search for value_i). Mode 3 is dropped without effect. Clear and
// append finish in the cycle they are taken, busy_o never rises, and a new
// command can follow on the next edge; a query that follows an append sees
// the new element. A query runs two binary searches, one after the other,
// over the filled part of the table: the first narrows left on a match to
// find the first occurrence, the second narrows right for the last. The
// memory read of the next midpoint is issued in the same cycle that the
// previous read data is compared. With n elements a pass takes at most
// floor(log2(n)) + 1 probes; a query holds busy_o until both passes are
// done and then delivers its result, and an empty table answers without
// raising busy_o. The result transfer is a one-cycle pulse on done_o with
// found_o, first_index_o and last_index_o valid alongside; the receiver
// cannot stall it, so capture it in that cycle. busy_o is already low
// during the done_o cycle, so the next command can be taken there.
// Indices are 0 for a search that met no match and are carried on 10
// bits. The table is expected in nondecreasing order; an unsorted table
// still gives a deterministic answer from the same probe sequence.
module first_last_occurrence_search #(
  parameter int unsigned TableDepth = flos_pkg::DefaultDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [flos_pkg::ModeW-1:0]          mode_i,
  input  logic signed [flos_pkg::ValueW-1:0]  value_i,
  output logic                                done_o,
  output logic                                found_o,
  output logic [flos_pkg::OutIdxW-1:0]        first_index_o,
  output logic [flos_pkg::OutIdxW-1:0]        last_index_o
);
  import flos_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  // Table memory: written by appends, read by the search sequencer.
  logic signed [ValueW-1:0] table_mem [TableDepth];
  logic signed [ValueW-1:0] rdata_q;

  logic [CntW-1:0]  count_q, count_d;
  logic             accept;
  logic             cmd_clear;
  logic             cmd_append;
  logic             cmd_query;
  logic             table_full;
  logic             wr_en;
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  logic             search_busy;
  logic             search_done;
  result_t          result;

  assign accept     = start_i && !search_busy;
  assign cmd_clear  = accept && (mode_i == ModeClear);
  assign cmd_append = accept && (mode_i == ModeAppend);
  assign cmd_query  = accept && (mode_i == ModeQuery);
  assign table_full = (count_q == CntW'(TableDepth));
  assign wr_en      = cmd_append && !table_full;

  // Element count: clear drops it to zero, an append advances it until full.
  always_comb begin
    count_d = count_q;
    priority if (cmd_clear) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Writes only happen while the sequencer is idle and a query never starts
  // in the same cycle as an append, so read and write never collide.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[count_q[IdxW-1:0]] <= value_i;
    end
    if (rd_en) begin
      rdata_q <= table_mem[rd_addr];
    end
  end

  flos_search #(
    .TableDepth (TableDepth)
  ) u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (cmd_query),
    .count_i   (count_q),
    .target_i  (value_i),
    .rdata_i   (rdata_q),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .busy_o    (search_busy),
    .done_o    (search_done),
    .result_o  (result)
  );

  assign busy_o        = search_busy;
  assign done_o        = search_done;
  assign found_o       = result.found;
  assign first_index_o = result.first_index;
  assign last_index_o  = result.last_index;

endmodule

// File: verif/flos_checker.sv
// Checker for the first/last occurrence search: mirrors the table, predicts and compares answers.
module flos_checker #(
  parameter int unsigned TableDepth = flos_pkg::DefaultDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_i,
  input  logic [flos_pkg::ModeW-1:0]         mode_i,
  input  logic signed [flos_pkg::ValueW-1:0] value_i,
  input  logic                               done_i,
  input  logic                               found_i,
  input  logic [flos_pkg::OutIdxW-1:0]       first_index_i,
  input  logic [flos_pkg::OutIdxW-1:0]       last_index_i,
  output int                                 mismatch_count_o,
  output int                                 pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import flos_pkg::*;

  logic signed [ValueW-1:0] table_mirror [TableDepth];
  int                       entry_count;
  result_t                  answer_q [$];

  // One binary search over the filled entries; narrow left or right on a hit.
  function automatic void bound_search(input logic signed [ValueW-1:0] target,
                                       input bit go_left, output bit hit,
                                       output int unsigned pos);
    int lo;
    int hi;
    int mid;
    logic signed [ValueW-1:0] probe;
    lo  = 0;
    hi  = entry_count - 1;
    hit = 1'b0;
    pos = 0;
    while (lo <= hi) begin
      mid   = lo + (hi - lo) / 2;
      probe = table_mirror[mid];
      if (probe == target) begin
        hit = 1'b1;
        pos = mid;
        if (go_left) hi = mid - 1;
        else lo = mid + 1;
      end else if (target < probe) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
  endfunction

  task automatic report(input string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    result_t     want;
    bit          hit_first;
    bit          hit_last;
    int unsigned pos_first;
    int unsigned pos_last;
    if (!rst_ni) begin
      entry_count = 0;
      answer_q.delete();
    end else begin
      if (done_i === 1'b1) begin
        if (answer_q.size() == 0) begin
          report($sformatf("unexpected answer found=%0b first=%0d last=%0d",
                           found_i, first_index_i, last_index_i));
        end else begin
          want = answer_q.pop_front();
          if ({found_i, first_index_i, last_index_i} !== want)
            report($sformatf({"expected found=%0b first=%0d last=%0d, ",
                              "got found=%0b first=%0d last=%0d"},
                             want.found, want.first_index, want.last_index,
                             found_i, first_index_i, last_index_i));
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        case (mode_i)
          ModeClear: entry_count = 0;
          ModeAppend: begin
            if (entry_count < TableDepth) begin
              table_mirror[entry_count] = value_i;
              entry_count++;
            end
          end
          ModeQuery: begin
            bound_search(value_i, 1'b1, hit_first, pos_first);
            bound_search(value_i, 1'b0, hit_last, pos_last);
            want.found       = hit_first | hit_last;
            want.first_index = pos_first[OutIdxW-1:0];
            want.last_index  = pos_last[OutIdxW-1:0];
            answer_q.push_back(want);
          end
          default: ;
        endcase
      end
    end
    pending_count_o = answer_q.size();
  end

endmodule

// File: verif/tb_first_last_occurrence_search.sv
// Testbench top for the first/last occurrence search: clock, reset, command stimulus and verdict.
module tb_first_last_occurrence_search;
  timeunit 1ns;
  timeprecision 1ps;
  import flos_pkg::*;

  localparam int unsigned TableDepth = DefaultDepth;
  // Mode 3 has no meaning; the block must drop it.
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;
  localparam int ItemTarget = 2000;
  localparam int QuietTail  = 300;
  localparam logic signed [ValueW-1:0] MinValue = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] MaxValue = 32'sh7FFF_FFFF;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [ModeW-1:0]         mode_i;
  logic signed [ValueW-1:0] value_i;
  logic                     done_o;
  logic                     found_o;
  logic [OutIdxW-1:0]       first_index_o;
  logic [OutIdxW-1:0]       last_index_o;
  int                       mismatch_count;
  int                       pending_count;

  // Idle bursts between commands; switched off for the last part of the run.
  bit                       idle_on;
  int                       item_count;
  // Values taken since the last clear; used for query targets and the full check.
  logic signed [ValueW-1:0] table_shadow [$];

  first_last_occurrence_search #(
    .TableDepth(TableDepth)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .found_o      (found_o),
    .first_index_o(first_index_o),
    .last_index_o (last_index_o)
  );

  flos_checker #(
    .TableDepth(TableDepth)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .mode_i          (mode_i),
    .value_i         (value_i),
    .done_i          (done_o),
    .found_i         (found_o),
    .first_index_i   (first_index_o),
    .last_index_i    (last_index_o),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Drive one command and hold it until a transfer happens. Inputs change
  // on the falling edge only; busy_o is sampled on the rising edge. start_i
  // is left high on return so that back-to-back commands never drop it.
  task automatic issue(input logic [ModeW-1:0] mode, input logic signed [ValueW-1:0] value);
    bit taken;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start_i = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    start_i = 1'b1;
    mode_i  = mode;
    value_i = value;
    taken   = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy_o;
      @(negedge clk_i);
    end
  endtask

  // Append and keep the local view and the item count in step. Appends to
  // a full table are dropped by the block, so they do not count as items.
  task automatic append_value(input logic signed [ValueW-1:0] value);
    issue(ModeAppend, value);
    if (table_shadow.size() < TableDepth) begin
      table_shadow.push_back(value);
      item_count++;
    end
  endtask

  task automatic clear_table();
    issue(ModeClear, $urandom);
    table_shadow.delete();
    item_count++;
  endtask

  task automatic query_value(input logic signed [ValueW-1:0] target);
    issue(ModeQuery, target);
    item_count++;
  endtask

  // Hold off the sender until every outstanding answer has arrived.
  task automatic drain();
    start_i = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  // Pick a target: mostly stored values and their neighbors, some extremes, some random.
  function automatic logic signed [ValueW-1:0] pick_target();
    logic signed [ValueW-1:0] base;
    base = (table_shadow.size() != 0) ?
           table_shadow[$urandom_range(0, table_shadow.size() - 1)] : $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2: return base;
      3:       return base + 1;
      4:       return base - 1;
      5:       return ($urandom_range(0, 1) == 0) ? MinValue : MaxValue;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int       seq_len;
    int       n_query;
    int       guard;
    bit       unsorted;
    bit       full_done;
    longint   cur;
    start_i    = 1'b0;
    mode_i     = ModeClear;
    value_i    = '0;
    rst_ni     = 1'b0;
    idle_on    = 1'b1;
    item_count = 0;
    full_done  = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, extreme values, duplicates at the low end and in
    // the middle, misses between entries, the unused mode, and stale data after clear.
    query_value(0);
    append_value(MinValue);
    append_value(MinValue);
    append_value(-1);
    append_value(0);
    append_value(0);
    append_value(0);
    append_value(5);
    append_value(MaxValue);
    query_value(MinValue);
    query_value(0);
    query_value(MaxValue);
    query_value(-1);
    query_value(1);
    query_value(6);
    issue(ModeUnused, 32'sh5A5A_A5A5);
    query_value(5);
    clear_table();
    query_value(0);
    append_value(7);
    query_value(7);
    query_value(6);
    query_value(8);
    drain();

    // Random: clear, fill with a mostly sorted random run, then query.
    // The first pass fills the whole table and overruns it.
    while (item_count < ItemTarget) begin
      idle_on = (item_count < ItemTarget - QuietTail);
      if (!full_done) seq_len = TableDepth + 6;
      else if ($urandom_range(0, 9) < 7) seq_len = $urandom_range(0, 24);
      else seq_len = $urandom_range(25, 150);
      // Now and then skip the clear so the new run lands on top of the old one.
      if (!full_done || $urandom_range(0, 7) != 0) clear_table();
      unsorted = full_done && ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 3))
        0:       cur = MinValue;
        1:       cur = longint'(MaxValue) - 3 * seq_len;
        2:       cur = longint'($urandom_range(0, 200)) - 100;
        default: cur = longint'(signed'(32'($urandom)));
      endcase
      for (int i = 0; i < seq_len; i++) begin
        if (cur > longint'(MaxValue)) cur = MaxValue;
        append_value(unsorted ? $urandom : 32'(cur));
        cur += $urandom_range(0, 3);
        if ($urandom_range(0, 39) == 0) issue(ModeUnused, $urandom);
      end
      n_query = full_done ? $urandom_range(1, 8) : 16;
      full_done = 1'b1;
      for (int i = 0; i < n_query; i++) query_value(pick_target());
      if ($urandom_range(0, 19) == 0) drain();
    end

    // Wind down: stop sending, wait for the last answers, then let the
    // block settle for longer than one full query.
    start_i = 1'b0;
    guard   = 0;
    while (pending_count != 0 && guard < 1000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (40) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
